// ===== sv/irat_pkg.sv =====
package irat_pkg;

    localparam int TableDepth = 64;
    localparam int KeyBits    = 32;
    localparam int ValueBits  = 32;

    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] range_start;
        logic [31:0] range_stop;
        logic [31:0] new_value;
        logic [31:0] probe_key;
    } t_in_item;

    typedef struct packed {
        logic [31:0] found_value;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_COPY,
        S_COMMIT,
        S_OUT
    } t_state;

endpackage

// ===== sv/interval_range_assign_table.sv =====
// Interval map with range assignment over a sorted table of breakpoints.
// Input channel: i_in_valid / o_in_stall with payload i_in_item (cmd, range
// bounds, value, probe key). Output channel: o_out_valid / i_out_stall with
// payload o_out_item (found value, status). One result item per input item.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_data writes the initial
// value and reloads the table to a single breakpoint at the lowest key.
// The block handles one item at a time and stalls its input meanwhile.
// A lookup walks the used entries once; an empty assign does not walk them.
// An assign walks the entries once to count and find the value in force at
// the range end, then once more to build the new table in a second bank, and
// swaps banks; a refused assign on a full table makes the first walk only.
// The walk is set by the single read port of each table memory.
// After reset the table holds one breakpoint at the lowest key with value 0;
// no clearing pass is needed, since only the fill count marks valid entries.
// When the receiver stalls, the result waits in the output register. The
// next item may still be taken in and worked on, but its result is held
// back until the output register has been emptied.
module interval_range_assign_table
    import irat_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepth,
    parameter int KEY_BITS    = KeyBits,
    parameter int VALUE_BITS  = ValueBits
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_BITS-1:0] KeyTop = '1;
    localparam logic [KEY_BITS-1:0] KeyHalf = {1'b1, {(KEY_BITS-1){1'b0}}};

    // Two banks; the active one is selected by r_bank.
    logic [KEY_BITS-1:0]   r_keys0 [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   r_keys1 [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] r_vals0 [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] r_vals1 [TABLE_DEPTH];
    logic                  r_bank;

    t_state r_state, n_state;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_idx;      // read pointer, one ahead of data
    logic [CW-1:0] r_ridx;     // index of registered read data
    logic          r_rvalid;
    logic [CW-1:0] r_wr;       // write pointer into other bank
    logic [CW-1:0] r_nlt, r_ngt;
    logic [1:0]    r_phase;    // copy phase: 0 low, 1 begin, 2 end, 3 high
    logic [KEY_BITS-1:0]   r_b, r_e, r_probe;
    logic [VALUE_BITS-1:0] r_val, r_hit, r_endv;
    logic          r_cmd;
    logic [1:0]    r_status;
    logic          r_out_valid;
    t_out_item     r_out;
    logic [KEY_BITS-1:0]   r_rkey;
    logic [VALUE_BITS-1:0] r_rval;

    logic in_acc, at_top, wr_en;
    logic [CW-1:0] total;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    logic [KEY_BITS-1:0]   in_b, in_e, in_p;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign at_top      = (r_e == KeyTop);
    assign total       = r_nlt + CW'(1) + (at_top ? CW'(0) : CW'(1)) + r_ngt;

    // A walk starts at entry 0, so the read is aimed there before it begins.
    assign rd_addr = (r_state == S_IDLE || r_state == S_CHECK) ? '0 : r_idx[AW-1:0];

    assign in_b = i_in_item.range_start[KEY_BITS-1:0] + KeyHalf;
    assign in_e = i_in_item.range_stop[KEY_BITS-1:0] + KeyHalf;
    assign in_p = i_in_item.probe_key[KEY_BITS-1:0] + KeyHalf;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.cmd == CMD_ASSIGN && !(in_b < in_e)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rvalid && r_ridx == r_used - CW'(1)) begin
                    n_state = (r_cmd == CMD_LOOKUP) ? S_OUT : S_CHECK;
                end
            end
            S_CHECK: n_state = (total > CW'(TABLE_DEPTH)) ? S_OUT : S_COPY;
            S_COPY: begin
                if (r_phase == 2'd3 && r_wr == total) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_OUT;
            S_OUT: if (!r_out_valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Copy phase write data into the inactive bank.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr[AW-1:0];
        wr_key  = r_rkey;
        wr_val  = r_rval;
        if (r_state == S_COPY && r_wr < total) begin
            case (r_phase)
                2'd0: wr_en = r_rvalid && r_ridx < r_nlt;
                2'd1: begin
                    wr_en  = 1'b1;
                    wr_key = r_b;
                    wr_val = r_val;
                end
                2'd2: begin
                    wr_en  = 1'b1;
                    wr_key = r_e;
                    wr_val = r_endv;
                end
                2'd3: wr_en = r_rvalid && r_ridx >= r_used - r_ngt;
                default: wr_en = 1'b0;
            endcase
        end
    end

    // Table memories: registered read of active bank, copy writes to the other.
    always_ff @(posedge i_clk) begin
        r_rkey <= r_bank ? r_keys1[rd_addr] : r_keys0[rd_addr];
        r_rval <= r_bank ? r_vals1[rd_addr] : r_vals0[rd_addr];
        if (wr_en) begin
            if (r_bank) begin
                r_keys0[wr_addr] <= wr_key;
                r_vals0[wr_addr] <= wr_val;
            end else begin
                r_keys1[wr_addr] <= wr_key;
                r_vals1[wr_addr] <= wr_val;
            end
        end
        if (!i_rst_n) begin
            r_keys0[0] <= '0;
            r_vals0[0] <= '0;
        end else if (r_state == S_IDLE && i_cfg_valid) begin
            if (r_bank) begin
                r_keys1[0] <= '0;
                r_vals1[0] <= VALUE_BITS'(i_cfg_data);
            end else begin
                r_keys0[0] <= '0;
                r_vals0[0] <= VALUE_BITS'(i_cfg_data);
            end
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_used      <= CW'(1);
            r_out_valid <= 1'b0;
            r_rvalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_used <= CW'(1);
                    end
                    r_cmd    <= i_in_item.cmd;
                    r_b      <= in_b;
                    r_e      <= in_e;
                    r_probe  <= (i_in_item.cmd == CMD_LOOKUP) ? in_p : in_e;
                    r_val    <= i_in_item.new_value[VALUE_BITS-1:0];
                    r_status <= (i_in_item.cmd == CMD_ASSIGN && !(in_b < in_e))
                                ? ST_EMPTY : ST_DONE;
                    r_idx    <= CW'(1);
                    r_ridx   <= '0;
                    r_rvalid <= in_acc;
                    r_nlt    <= '0;
                    r_ngt    <= '0;
                end
                S_SCAN: begin
                    if (r_rvalid) begin
                        if (r_ridx == '0 || r_rkey <= r_probe) r_hit <= r_rval;
                        if (r_rkey < r_b) r_nlt <= r_nlt + CW'(1);
                        else if (r_rkey > r_e && !at_top) r_ngt <= r_ngt + CW'(1);
                    end
                    r_ridx   <= r_idx;
                    r_rvalid <= (r_idx < r_used);
                    r_idx    <= r_idx + CW'(1);
                end
                S_CHECK: begin
                    r_endv  <= r_hit;
                    r_status <= (total > CW'(TABLE_DEPTH)) ? ST_FULL : ST_DONE;
                    r_phase <= 2'd0;
                    r_wr    <= '0;
                    r_idx   <= CW'(1);
                    r_ridx  <= '0;
                    r_rvalid <= 1'b1;
                end
                S_COPY: begin
                    if (wr_en) r_wr <= r_wr + CW'(1);
                    case (r_phase)
                        2'd0: begin
                            if (!(r_rvalid && r_ridx < r_nlt)) begin
                                r_phase <= 2'd1;
                            end else begin
                                r_ridx   <= r_idx;
                                r_rvalid <= (r_idx < r_used);
                                r_idx    <= r_idx + CW'(1);
                            end
                        end
                        2'd1: begin
                            r_phase <= at_top ? 2'd3 : 2'd2;
                            r_idx   <= r_used - r_ngt;
                            r_rvalid <= 1'b0;
                        end
                        2'd2: r_phase <= 2'd3;
                        default: begin
                            r_ridx   <= r_idx;
                            r_rvalid <= (r_idx < r_used);
                            r_idx    <= r_idx + CW'(1);
                        end
                    endcase
                end
                S_COMMIT: begin
                    r_bank <= !r_bank;
                    r_used <= total;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid       <= 1'b1;
                        r_out.status      <= r_status;
                        r_out.found_value <= (r_cmd == CMD_LOOKUP)
                                             ? 32'(r_hit) : '0;
                    end
                end
                default: r_rvalid <= 1'b0;
            endcase
        end
    end

endmodule

// ===== test/interval_range_assign_table_test.sv =====
`timescale 1ns / 100ps

module interval_range_assign_table_test;
    import irat_pkg::*;

    localparam int Depth = 64;
    localparam int CycleLimit = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [31:0] i_cfg_data;

    interval_range_assign_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Predicted table, keys held in offset binary so unsigned order applies.
    logic [31:0] bp_keys[Depth];
    logic [31:0] bp_vals[Depth];
    int          bp_used;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int errors = 0;
    int cycles = 0;
    int accepted = 0;
    int delivered = 0;
    int full_seen = 0;
    bit calm = 0;
    int in_gap = 0;
    int out_gap = 0;

    // Pending configuration write, handled by the driver when requested.
    bit          cfg_req = 0;
    logic [31:0] cfg_word;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ordered(logic [31:0] k);
        return k ^ 32'h8000_0000;
    endfunction

    function automatic logic [31:0] value_in_force(logic [31:0] k);
        logic [31:0] v;
        v = bp_vals[0];
        for (int i = 0; i < bp_used; i++)
            if (bp_keys[i] <= k) v = bp_vals[i];
        return v;
    endfunction

    function automatic void reload_table(logic [31:0] v);
        bp_keys[0] = '0;
        bp_vals[0] = v;
        bp_used = 1;
    endfunction

    // Applies one item to the predicted table and returns the result it causes.
    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        logic [31:0] b, e, end_val;
        logic [31:0] nk[Depth];
        logic [31:0] nv[Depth];
        int nlt, ngt, total, w;
        bit top;
        r = '0;
        if (it.cmd == CMD_LOOKUP) begin
            r.found_value = value_in_force(ordered(it.probe_key));
            r.status = ST_DONE;
            return r;
        end
        b = ordered(it.range_start);
        e = ordered(it.range_stop);
        top = (e == 32'hFFFF_FFFF);
        if (!(b < e)) begin
            r.status = ST_EMPTY;
            return r;
        end
        end_val = value_in_force(e);
        nlt = 0;
        ngt = 0;
        for (int i = 0; i < bp_used; i++) begin
            if (bp_keys[i] < b) nlt++;
            else if (bp_keys[i] > e && !top) ngt++;
        end
        total = nlt + 1 + (top ? 0 : 1) + ngt;
        if (total > Depth) begin
            r.status = ST_FULL;
            return r;
        end
        w = 0;
        for (int i = 0; i < nlt; i++) begin
            nk[w] = bp_keys[i];
            nv[w] = bp_vals[i];
            w++;
        end
        nk[w] = b;
        nv[w] = it.new_value;
        w++;
        if (!top) begin
            nk[w] = e;
            nv[w] = end_val;
            w++;
        end
        for (int i = bp_used - ngt; i < bp_used; i++) begin
            nk[w] = bp_keys[i];
            nv[w] = bp_vals[i];
            w++;
        end
        for (int i = 0; i < w; i++) begin
            bp_keys[i] = nk[i];
            bp_vals[i] = nv[i];
        end
        bp_used = total;
        r.status = ST_DONE;
        return r;
    endfunction

    // Driver: presents queued items with random bursts of idling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                i_cfg_valid <= 1'b0;
                cfg_req = 0;
                reload_table(cfg_word);
            end else if (cfg_req && !i_cfg_valid) begin
                i_cfg_valid <= 1'b1;
                i_cfg_data <= cfg_word;
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_result(i_in_item));
                accepted++;
                void'(pending_items.pop_front());
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !cfg_req) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pending_items[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the result channel at random and checks each item.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    delivered++;
                    if (exp_r.status == ST_FULL) full_seen++;
                    if (o_out_item.found_value !== exp_r.found_value) begin
                        $error("found_value expected %h actual %h",
                               exp_r.found_value, o_out_item.found_value);
                        errors++;
                    end
                    if (o_out_item.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d",
                               exp_r.status, o_out_item.status);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("interval_range_assign_table_test: FAIL");
            $finish;
        end
    end

    function automatic t_in_item make_assign(logic [31:0] s, logic [31:0] e, logic [31:0] v);
        t_in_item it;
        it = '0;
        it.cmd = CMD_ASSIGN;
        it.range_start = s;
        it.range_stop = e;
        it.new_value = v;
        it.probe_key = $urandom;
        return it;
    endfunction

    function automatic t_in_item make_lookup(logic [31:0] k);
        t_in_item it;
        it = '0;
        it.cmd = CMD_LOOKUP;
        it.probe_key = k;
        it.range_start = $urandom;
        it.range_stop = $urandom;
        it.new_value = $urandom;
        return it;
    endfunction

    // Keys drawn mostly from a narrow window so ranges overlap often.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 200) - 100;
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_initial(logic [31:0] v);
        cfg_word = v;
        cfg_req = 1;
        while (cfg_req) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] a, b;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_item = '0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        reload_table('0);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part: extremes, empty ranges, the top key and the bottom key.
        pending_items.push_back(make_lookup(32'h8000_0000));
        pending_items.push_back(make_lookup(32'h7FFF_FFFF));
        pending_items.push_back(make_assign(32'd10, 32'd10, 32'hFFFF_FFFF));
        pending_items.push_back(make_assign(32'd20, 32'd5, 32'h1));
        pending_items.push_back(make_assign(32'h8000_0000, 32'd0, 32'hAAAA_5555));
        pending_items.push_back(make_assign(32'd0, 32'h7FFF_FFFF, 32'h5555_AAAA));
        pending_items.push_back(make_lookup(32'h7FFF_FFFF));
        pending_items.push_back(make_lookup(32'hFFFF_FFFF));
        pending_items.push_back(make_assign(-32'sd5, 32'd5, 32'hFFFF_FFFF));
        pending_items.push_back(make_lookup(-32'sd5));
        pending_items.push_back(make_lookup(32'd5));
        pending_items.push_back(make_lookup(-32'sd6));
        pending_items.push_back(make_assign(32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
        pending_items.push_back(make_lookup(32'h0));
        drain();
        write_initial(32'hFFFF_FFFF);
        pending_items.push_back(make_lookup(32'h1234_5678));
        // Fill the table until it overflows.
        for (int i = 0; i < 34; i++)
            pending_items.push_back(make_assign(i * 4, i * 4 + 2, i));
        drain();

        // Random part in several settings of the initial value.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_initial(32'h0);
                1: write_initial(32'hFFFF_FFFF);
                default: write_initial($urandom);
            endcase
            if (phase == 4) calm = 1;
            for (int n = 0; n < 220; n++) begin
                if ($urandom_range(0, 2) == 0) begin
                    pending_items.push_back(make_lookup(pick_key()));
                end else begin
                    a = pick_key();
                    b = pick_key();
                    if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(b))
                        pending_items.push_back(make_assign(b, a, $urandom));
                    else
                        pending_items.push_back(make_assign(a, b, $urandom));
                end
            end
            drain();
        end

        $display("Covered %0d items (%0d results, %0d overflow refusals) over seven settings.",
                 accepted, delivered, full_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("interval_range_assign_table_test: PASS");
        end else begin
            $display("interval_range_assign_table_test: FAIL");
        end
        $finish;
    end

endmodule
